@@ rtl/core/spherical_circumcenter_unit_assert.svh @@
//------------------------------------------------------------------------------
// spherical_circumcenter_unit_assert
// assertion macros for the spherical circumcenter unit
//------------------------------------------------------------------------------
`ifndef SPHERICAL_CIRCUMCENTER_UNIT_ASSERT_SVH
`define SPHERICAL_CIRCUMCENTER_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define SCC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/scc_pkg.sv @@
//------------------------------------------------------------------------------
// scc_pkg
// types, widths and constants of the spherical circumcenter unit
//------------------------------------------------------------------------------
`default_nettype none
package scc_pkg;

	localparam int unsigned CoordW = 16;
	localparam int unsigned DiffW  = 17;
	localparam int unsigned SqW    = 36;
	localparam int unsigned NW     = 35;
	localparam int unsigned PW     = 53;
	localparam int unsigned CcW    = 92;
	localparam int unsigned MagW   = 31;
	localparam int unsigned SumW   = 64;
	localparam int unsigned RootW  = 32;
	localparam int unsigned NumW   = 46;
	localparam int unsigned QuoW   = 46;
	localparam int unsigned CenterMax = 32767;
	localparam int unsigned UnitScale = 16384;

	// split points of the wide weighting products
	localparam int unsigned PLoW   = 26;
	localparam int unsigned PProdW = SqW + PW - PLoW;
	localparam int unsigned NsqW   = 72;
	localparam int unsigned NsqLoW = 36;
	localparam int unsigned NProdW = NsqLoW + 1 + CoordW;

	typedef logic signed [CoordW-1:0] coord_t;

	typedef struct packed {
		coord_t a_x;
		coord_t a_y;
		coord_t a_z;
		coord_t b_x;
		coord_t b_y;
		coord_t b_z;
		coord_t c_x;
		coord_t c_y;
		coord_t c_z;
	} tri_t;

	typedef struct packed {
		coord_t center_x;
		coord_t center_y;
		coord_t center_z;
		logic   degenerate;
	} center_t;

	typedef logic [MagW-1:0] mag_t;

	// normalizer handoff
	typedef struct packed {
		logic       degenerate;
		logic [2:0] neg;
		mag_t       m_x;
		mag_t       m_y;
		mag_t       m_z;
	} norm_t;

endpackage
`default_nettype wire

@@ rtl/core/scc_if.sv @@
//------------------------------------------------------------------------------
// scc_tri_if / scc_center_if
// valid/ready channels of the spherical circumcenter unit
//------------------------------------------------------------------------------
`default_nettype none
interface scc_tri_if;
	import scc_pkg::*;
	logic valid;
	logic ready;
	tri_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface scc_center_if;
	import scc_pkg::*;
	logic    valid;
	logic    ready;
	center_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/scc_vec.sv @@
//------------------------------------------------------------------------------
// scc_vec
// exact integer center vector: differences, cross products, weighted sum,
// then leading-bit alignment down to 31-bit magnitudes
//------------------------------------------------------------------------------
`default_nettype none
module scc_vec (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire scc_pkg::tri_t   tri_in,
	output logic                 out_valid,
	output scc_pkg::norm_t       norm_out
);
	import scc_pkg::*;

	// stage 1: differences, squared lengths
	logic signed [DiffW-1:0] ab_s1 [3];
	logic signed [DiffW-1:0] ac_s1 [3];
	logic signed [CoordW-1:0] a_s1 [3];
	logic signed [SqW-1:0] absq_s1, acsq_s1;
	logic v_s1;
	// stage 2: normal
	logic signed [NW-1:0] n_s2 [3];
	logic signed [DiffW-1:0] ab_s2 [3];
	logic signed [DiffW-1:0] ac_s2 [3];
	logic signed [CoordW-1:0] a_s2 [3];
	logic signed [SqW-1:0] absq_s2, acsq_s2;
	logic v_s2;
	// stage 3: p, q, |n|^2
	logic signed [PW-1:0] p_s3 [3];
	logic signed [PW-1:0] q_s3 [3];
	logic signed [NsqW-1:0] nsq_s3;
	logic signed [CoordW-1:0] a_s3 [3];
	logic signed [SqW-1:0] absq_s3, acsq_s3;
	logic dgn_s3, v_s3;
	// stage 4: split partial products of the weighted terms
	logic signed [PProdW-1:0] t1lo_s4 [3];
	logic signed [PProdW-1:0] t1hi_s4 [3];
	logic signed [PProdW-1:0] t2lo_s4 [3];
	logic signed [PProdW-1:0] t2hi_s4 [3];
	logic signed [NProdW-1:0] t3lo_s4 [3];
	logic signed [NProdW-1:0] t3hi_s4 [3];
	logic dgn_s4, v_s4;
	// stage 5: exact center vector
	logic signed [CcW-1:0] cc_s5 [3];
	logic dgn_s5, v_s5;
	// stage 6: magnitude and sign
	logic [CcW-1:0] m_s6 [3];
	logic [2:0] neg_s6;
	logic dgn_s6, v_s6;
	// stage 7: aligned magnitudes
	norm_t n_s7;
	logic v_s7;

	logic signed [DiffW-1:0] ab_c [3];
	logic signed [DiffW-1:0] ac_c [3];
	logic signed [CoordW-1:0] a_c [3];
	logic [CcW-1:0] orv_c;
	logic [6:0] k_c;
	logic [CcW-1:0] sh_c [3];

	always_comb begin
		a_c[0] = tri_in.a_x; a_c[1] = tri_in.a_y; a_c[2] = tri_in.a_z;
		ab_c[0] = DiffW'(tri_in.b_x) - DiffW'(tri_in.a_x);
		ab_c[1] = DiffW'(tri_in.b_y) - DiffW'(tri_in.a_y);
		ab_c[2] = DiffW'(tri_in.b_z) - DiffW'(tri_in.a_z);
		ac_c[0] = DiffW'(tri_in.c_x) - DiffW'(tri_in.a_x);
		ac_c[1] = DiffW'(tri_in.c_y) - DiffW'(tri_in.a_y);
		ac_c[2] = DiffW'(tri_in.c_z) - DiffW'(tri_in.a_z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				a_s1[i]  <= a_c[i];
				ab_s1[i] <= ab_c[i];
				ac_s1[i] <= ac_c[i];
			end
			absq_s1 <= SqW'(ab_c[0] * ab_c[0]) + SqW'(ab_c[1] * ab_c[1])
				+ SqW'(ab_c[2] * ab_c[2]);
			acsq_s1 <= SqW'(ac_c[0] * ac_c[0]) + SqW'(ac_c[1] * ac_c[1])
				+ SqW'(ac_c[2] * ac_c[2]);

			n_s2[0] <= NW'(ab_s1[1] * ac_s1[2]) - NW'(ab_s1[2] * ac_s1[1]);
			n_s2[1] <= NW'(ab_s1[2] * ac_s1[0]) - NW'(ab_s1[0] * ac_s1[2]);
			n_s2[2] <= NW'(ab_s1[0] * ac_s1[1]) - NW'(ab_s1[1] * ac_s1[0]);
			ab_s2 <= ab_s1; ac_s2 <= ac_s1; a_s2 <= a_s1;
			absq_s2 <= absq_s1; acsq_s2 <= acsq_s1;

			p_s3[0] <= PW'(n_s2[1] * ab_s2[2]) - PW'(n_s2[2] * ab_s2[1]);
			p_s3[1] <= PW'(n_s2[2] * ab_s2[0]) - PW'(n_s2[0] * ab_s2[2]);
			p_s3[2] <= PW'(n_s2[0] * ab_s2[1]) - PW'(n_s2[1] * ab_s2[0]);
			q_s3[0] <= PW'(ac_s2[1] * n_s2[2]) - PW'(ac_s2[2] * n_s2[1]);
			q_s3[1] <= PW'(ac_s2[2] * n_s2[0]) - PW'(ac_s2[0] * n_s2[2]);
			q_s3[2] <= PW'(ac_s2[0] * n_s2[1]) - PW'(ac_s2[1] * n_s2[0]);
			nsq_s3 <= NsqW'(n_s2[0] * n_s2[0]) + NsqW'(n_s2[1] * n_s2[1])
				+ NsqW'(n_s2[2] * n_s2[2]);
			dgn_s3 <= (n_s2[0] == '0) && (n_s2[1] == '0) && (n_s2[2] == '0);
			a_s3 <= a_s2; absq_s3 <= absq_s2; acsq_s3 <= acsq_s2;

			// low halves taken as unsigned, high halves keep the sign
			for (int i = 0; i < 3; i++) begin
				t1lo_s4[i] <= PProdW'(acsq_s3 * $signed({1'b0, p_s3[i][PLoW-1:0]}));
				t1hi_s4[i] <= PProdW'(acsq_s3 * $signed(p_s3[i][PW-1:PLoW]));
				t2lo_s4[i] <= PProdW'(absq_s3 * $signed({1'b0, q_s3[i][PLoW-1:0]}));
				t2hi_s4[i] <= PProdW'(absq_s3 * $signed(q_s3[i][PW-1:PLoW]));
				t3lo_s4[i] <= NProdW'($signed({1'b0, nsq_s3[NsqLoW-1:0]}) * a_s3[i]);
				t3hi_s4[i] <= NProdW'($signed(nsq_s3[NsqW-1:NsqLoW]) * a_s3[i]);
			end
			dgn_s4 <= dgn_s3;

			for (int i = 0; i < 3; i++) begin
				cc_s5[i] <= ((CcW'(t1hi_s4[i]) + CcW'(t2hi_s4[i])) <<< PLoW)
					+ CcW'(t1lo_s4[i]) + CcW'(t2lo_s4[i])
					+ (((CcW'(t3hi_s4[i]) <<< NsqLoW) + CcW'(t3lo_s4[i])) <<< 1);
			end
			dgn_s5 <= dgn_s4;

			for (int i = 0; i < 3; i++) begin
				neg_s6[i] <= cc_s5[i][CcW-1];
				m_s6[i] <= cc_s5[i][CcW-1] ? CcW'(-cc_s5[i]) : CcW'(cc_s5[i]);
			end
			dgn_s6 <= dgn_s5 || (cc_s5[0] == '0 && cc_s5[1] == '0 && cc_s5[2] == '0);

			n_s7.degenerate <= dgn_s6;
			n_s7.neg <= neg_s6;
			n_s7.m_x <= sh_c[0][MagW-1:0];
			n_s7.m_y <= sh_c[1][MagW-1:0];
			n_s7.m_z <= sh_c[2][MagW-1:0];
		end
	end

	always_comb begin
		orv_c = m_s6[0] | m_s6[1] | m_s6[2];
		k_c = '0;
		for (int b = MagW; b < CcW; b++) begin
			if (orv_c[b]) k_c = 7'(b - MagW + 1);
		end
		for (int i = 0; i < 3; i++) sh_c[i] = m_s6[i] >> k_c;
	end

	assign out_valid = v_s7;
	assign norm_out  = n_s7;
endmodule
`default_nettype wire

@@ rtl/core/scc_norm.sv @@
//------------------------------------------------------------------------------
// scc_norm
// squared length, pipelined integer square root, pipelined rounded quotient
//------------------------------------------------------------------------------
`default_nettype none
module scc_norm (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  wire scc_pkg::norm_t   norm_in,
	output logic                  out_valid,
	output scc_pkg::center_t      center_out
);
	import scc_pkg::*;

	localparam int unsigned RootSteps = RootW;
	localparam int unsigned QSteps    = QuoW;

	// root pipeline, one result bit per stage; entry 0 is the squared length stage
	logic [SumW-1:0]  rem_r [RootSteps+1];
	logic [RootW-1:0] res_r [RootSteps+1];
	norm_t            nm_r  [RootSteps+1];
	logic             v_r   [RootSteps+1];

	// quotient pipeline, one bit per stage, three lanes; entry 0 is the dividend
	logic [NumW:0]    qrem [QSteps+1][3];
	logic [NumW-1:0]  qnum [QSteps+1][3];
	logic [QuoW-1:0]  qquo [QSteps+1][3];
	logic [RootW-1:0] qdiv [QSteps+1];
	norm_t            nm_q [QSteps+1];
	logic             v_q  [QSteps+1];

	center_t out_q;
	logic    vo_q;

	logic [RootW-1:0] rdiv_c;
	logic [NumW-1:0]  num_c [3];

	function automatic coord_t fin(input logic [QuoW-1:0] v, input logic ng, input logic dg);
		logic [CoordW-1:0] c;
		c = (v > QuoW'(CenterMax)) ? CoordW'(CenterMax) : v[CoordW-1:0];
		if (dg) return '0;
		return ng ? coord_t'(-c) : coord_t'(c);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 1'b0;
			for (int i = 0; i <= RootSteps; i++) v_r[i] <= 1'b0;
			for (int i = 0; i <= QSteps; i++) v_q[i] <= 1'b0;
		end else if (en) begin
			v_r[0] <= in_valid;
			for (int i = 1; i <= RootSteps; i++) v_r[i] <= v_r[i-1];
			v_q[0] <= v_r[RootSteps];
			for (int i = 1; i <= QSteps; i++) v_q[i] <= v_q[i-1];
			vo_q <= v_q[QSteps];
		end
	end

	// restoring root: bit j decided at stage RootSteps-j
	always_ff @(posedge clk) begin
		if (en) begin
			nm_r[0]  <= norm_in;
			res_r[0] <= '0;
			rem_r[0] <= SumW'(norm_in.m_x * norm_in.m_x) + SumW'(norm_in.m_y * norm_in.m_y)
				+ SumW'(norm_in.m_z * norm_in.m_z);
			for (int st = 0; st < RootSteps; st++) begin
				logic [RootW-1:0] trial;
				logic [SumW-1:0]  tsq;
				trial = res_r[st] | (RootW'(1) << (RootSteps - 1 - st));
				tsq = SumW'(trial) * SumW'(trial);
				if (tsq <= rem_r[st]) res_r[st+1] <= trial;
				else res_r[st+1] <= res_r[st];
				rem_r[st+1] <= rem_r[st];
				nm_r[st+1]  <= nm_r[st];
			end
		end
	end

	always_comb begin
		rdiv_c = (res_r[RootSteps] == '0) ? RootW'(1) : res_r[RootSteps];
		num_c[0] = NumW'(nm_r[RootSteps].m_x) * NumW'(UnitScale) + NumW'(rdiv_c >> 1);
		num_c[1] = NumW'(nm_r[RootSteps].m_y) * NumW'(UnitScale) + NumW'(rdiv_c >> 1);
		num_c[2] = NumW'(nm_r[RootSteps].m_z) * NumW'(UnitScale) + NumW'(rdiv_c >> 1);
	end

	// long division, msb first
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				qrem[0][l] <= '0;
				qnum[0][l] <= num_c[l];
				qquo[0][l] <= '0;
			end
			qdiv[0] <= rdiv_c;
			nm_q[0] <= nm_r[RootSteps];
			for (int st = 0; st < QSteps; st++) begin
				for (int l = 0; l < 3; l++) begin
					logic [NumW:0] sh;
					sh = {qrem[st][l][NumW-1:0], qnum[st][l][NumW-1]};
					if (sh >= (NumW+1)'(qdiv[st])) begin
						qrem[st+1][l] <= sh - (NumW+1)'(qdiv[st]);
						qquo[st+1][l] <= {qquo[st][l][QuoW-2:0], 1'b1};
					end else begin
						qrem[st+1][l] <= sh;
						qquo[st+1][l] <= {qquo[st][l][QuoW-2:0], 1'b0};
					end
					qnum[st+1][l] <= {qnum[st][l][NumW-2:0], 1'b0};
				end
				qdiv[st+1] <= qdiv[st];
				nm_q[st+1] <= nm_q[st];
			end
			out_q.degenerate <= nm_q[QSteps].degenerate;
			out_q.center_x <= fin(qquo[QSteps][0], nm_q[QSteps].neg[0], nm_q[QSteps].degenerate);
			out_q.center_y <= fin(qquo[QSteps][1], nm_q[QSteps].neg[1], nm_q[QSteps].degenerate);
			out_q.center_z <= fin(qquo[QSteps][2], nm_q[QSteps].neg[2], nm_q[QSteps].degenerate);
		end
	end

	assign out_valid  = vo_q;
	assign center_out = out_q;
endmodule
`default_nettype wire

@@ rtl/core/spherical_circumcenter_unit.sv @@
//------------------------------------------------------------------------------
// spherical_circumcenter_unit
// unit circumcenter of a spherical triangle given in Q2.14
//------------------------------------------------------------------------------
// channel    | dir | payload
// tri_in     | in  | a/b/c xyz, signed Q2.14
// center_out | out | center xyz Q2.14, degenerate flag
//
// one transaction accepted per cycle unless the output is stalled
// results pass the vector stages, square root and divider (one bit per stage)
// arst_n clears every valid bit; payload registers are not reset
// the whole pipeline holds while the output is stalled, nothing is lost
//------------------------------------------------------------------------------
`default_nettype none
`include "spherical_circumcenter_unit_assert.svh"
module spherical_circumcenter_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	scc_tri_if.sink     tri_in,
	scc_center_if.source center_out
);
	import scc_pkg::*;

	logic  en;
	logic  v_mid;
	norm_t mid;

	// global stall: advance when the last stage is empty or being taken
	assign en = !center_out.valid || center_out.ready;
	assign tri_in.ready = en;

	scc_vec u_vec (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(tri_in.valid && en), .tri_in(tri_in.data),
		.out_valid(v_mid), .norm_out(mid)
	);

	scc_norm u_norm (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_mid), .norm_in(mid),
		.out_valid(center_out.valid), .center_out(center_out.data)
	);

	`SCC_ASSERT_IMPL(a_hold, clk, arst_n, center_out.valid && !center_out.ready,
		!tri_in.ready, "input taken during output stall")
	`SCC_ASSERT_NEXT(a_stable, clk, arst_n, center_out.valid && !center_out.ready,
		center_out.valid && $stable(center_out.data), "stalled result changed")
	`SCC_ASSERT_IMPL(a_dgn_zero, clk, arst_n,
		center_out.valid && center_out.data.degenerate,
		center_out.data.center_x == '0 && center_out.data.center_y == '0
		&& center_out.data.center_z == '0, "degenerate result not zero")
endmodule
`default_nettype wire

@@ tb/sv/spherical_circumcenter_unit_checker.sv @@
//------------------------------------------------------------------------------
// spherical_circumcenter_unit_checker
// watches both channels, predicts each circumcenter and compares in order
//------------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module spherical_circumcenter_unit_checker
	import scc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   tri_valid,
	input  wire logic   tri_ready,
	input  tri_t        tri_data,
	input  wire logic   center_valid,
	input  wire logic   center_ready,
	input  center_t     center_data,
	output int          fail_count,
	output int          pending
);

	center_t expected_centers[$];

	function automatic logic [63:0] int_sqrt(input logic [63:0] s);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > s) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s = s - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic center_t circumcenter(input tri_t t);
		longint a[3], ab[3], ac[3], n[3], p[3], q[3];
		longint ab_sq, ac_sq;
		logic signed [127:0] cc[3];
		logic [127:0] m[3];
		logic [127:0] orv;
		logic [63:0] c[3];
		logic [63:0] s, r, v;
		logic neg[3];
		int k;
		center_t res;
		a[0] = t.a_x; a[1] = t.a_y; a[2] = t.a_z;
		ab[0] = longint'(t.b_x) - a[0]; ab[1] = longint'(t.b_y) - a[1];
		ab[2] = longint'(t.b_z) - a[2];
		ac[0] = longint'(t.c_x) - a[0]; ac[1] = longint'(t.c_y) - a[1];
		ac[2] = longint'(t.c_z) - a[2];
		ab_sq = ab[0]*ab[0] + ab[1]*ab[1] + ab[2]*ab[2];
		ac_sq = ac[0]*ac[0] + ac[1]*ac[1] + ac[2]*ac[2];
		n[0] = ab[1]*ac[2] - ab[2]*ac[1];
		n[1] = ab[2]*ac[0] - ab[0]*ac[2];
		n[2] = ab[0]*ac[1] - ab[1]*ac[0];
		res = '0;
		if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
			res.degenerate = 1'b1;
			return res;
		end
		p[0] = n[1]*ab[2] - n[2]*ab[1];
		p[1] = n[2]*ab[0] - n[0]*ab[2];
		p[2] = n[0]*ab[1] - n[1]*ab[0];
		q[0] = ac[1]*n[2] - ac[2]*n[1];
		q[1] = ac[2]*n[0] - ac[0]*n[2];
		q[2] = ac[0]*n[1] - ac[1]*n[0];
		orv = 0;
		for (int i = 0; i < 3; i++) begin
			// 128-bit exact accumulation of the unnormalized center
			cc[i] = 128'(signed'(ac_sq)) * 128'(signed'(p[i]))
				+ 128'(signed'(ab_sq)) * 128'(signed'(q[i]));
			for (int j = 0; j < 3; j++)
				cc[i] = cc[i] + 128'(signed'(2*a[i]*n[j])) * 128'(signed'(n[j]));
			neg[i] = cc[i][127];
			m[i] = neg[i] ? -cc[i] : cc[i];
			orv = orv | m[i];
		end
		if (orv == 0) begin
			res.degenerate = 1'b1;
			return res;
		end
		k = 0;
		while (orv >= (128'd1 << 31)) begin
			orv = orv >> 1;
			k++;
		end
		s = 0;
		for (int i = 0; i < 3; i++) begin
			c[i] = 64'(m[i] >> k);
			s = s + c[i]*c[i];
		end
		r = int_sqrt(s);
		if (r == 0) r = 1;
		for (int i = 0; i < 3; i++) begin
			v = (c[i]*64'd16384 + (r >> 1)) / r;
			if (v > 64'd32767) v = 64'd32767;
			if (neg[i]) v = -v;
			case (i)
				0: res.center_x = v[15:0];
				1: res.center_y = v[15:0];
				default: res.center_z = v[15:0];
			endcase
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		fail_count++;
	endtask

	assign pending = expected_centers.size();

	initial fail_count = 0;

	always @(posedge clk) begin
		center_t want;
		if (arst_n) begin
			if (tri_valid && tri_ready)
				expected_centers.push_back(circumcenter(tri_data));
			if (center_valid && center_ready) begin
				if (expected_centers.size() == 0) begin
					report_mismatch("unexpected transaction", 1, 0);
				end else begin
					want = expected_centers.pop_front();
					if (center_data.center_x !== want.center_x)
						report_mismatch("center_x", center_data.center_x, want.center_x);
					if (center_data.center_y !== want.center_y)
						report_mismatch("center_y", center_data.center_y, want.center_y);
					if (center_data.center_z !== want.center_z)
						report_mismatch("center_z", center_data.center_z, want.center_z);
					if (center_data.degenerate !== want.degenerate)
						report_mismatch("degenerate", center_data.degenerate,
							want.degenerate);
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ tb/sv/spherical_circumcenter_unit_test.sv @@
//------------------------------------------------------------------------------
// spherical_circumcenter_unit_test
// directed and random triangles through the circumcenter unit with random
// gaps on both sides and one long output stall; the checker compares results
//------------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module spherical_circumcenter_unit_test;
	import scc_pkg::*;

	localparam int RandomTriangles = 400;
	localparam int StallLimit      = 20000;  // cycles with no transaction at all
	localparam int DrainCycles     = 200;    // extra wait once the checker queue is empty

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   idle_cycles;

	scc_tri_if    tri_ch();
	scc_center_if center_ch();

	spherical_circumcenter_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.tri_in     (tri_ch.sink),
		.center_out (center_ch.source)
	);

	spherical_circumcenter_unit_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.tri_valid    (tri_ch.valid),
		.tri_ready    (tri_ch.ready),
		.tri_data     (tri_ch.data),
		.center_valid (center_ch.valid),
		.center_ready (center_ch.ready),
		.center_data  (center_ch.data),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// random components: mostly within +-16384, some any value, some 16'sh7fff
	function automatic tri_t sphere_tri();
		tri_t t;
		coord_t v[9];
		int pick;
		for (int i = 0; i < 9; i++) begin
			pick = $urandom_range(0, 9);
			if (pick < 6)
				v[i] = coord_t'($signed($urandom_range(0, 32768)) - 16384);
			else if (pick < 9)
				v[i] = coord_t'($urandom);
			else
				v[i] = (pick[0]) ? 16'sh7fff : 16'sh8000;
		end
		t = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
		// sometimes collapse a point so collinear cases keep showing up
		if ($urandom_range(0, 19) == 0) begin
			t.c_x = t.b_x; t.c_y = t.b_y; t.c_z = t.b_z;
		end
		return t;
	endfunction

	// valid stays high across back-to-back transactions
	task automatic send_tri(input tri_t t);
		int gap;
		gap = gap_length();
		if (gap > 0) begin
			tri_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tri_ch.valid <= 1'b1;
		tri_ch.data  <= t;
		@(posedge clk);
		while (!tri_ch.ready) @(posedge clk);
	endtask

	// receiver side: random backpressure, one long hold-off early on
	initial begin
		int gap;
		center_ch.ready = 1'b0;
		@(posedge arst_n);
		repeat (30) @(posedge clk);
		center_ch.ready <= 1'b0;
		repeat (400) @(posedge clk);
		forever begin
			center_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			gap = gap_length();
			if (gap > 0) begin
				center_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// watchdog on cycles where neither channel moves a transaction
	always @(posedge clk) begin
		if (!arst_n || (tri_ch.valid && tri_ch.ready) ||
				(center_ch.valid && center_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		tri_t t;
		tri_t directed[$];
		idle_cycles = 0;
		tri_ch.valid = 1'b0;
		tri_ch.data  = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// octant triangle, unit points on axes
		directed.push_back({16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
			16'sd0, 16'sd0, 16'sd16384});
		// mirrored octant
		directed.push_back({-16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
			16'sd0, 16'sd0, -16'sd16384});
		// all points equal: collinear
		directed.push_back({9{16'sd16384}});
		// all zero
		directed.push_back('0);
		// collinear distinct points
		directed.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd1,
			16'sd2, 16'sd2, 16'sd2});
		// extremes of every field
		directed.push_back({9{16'sh8000}});
		directed.push_back({9{16'sh7fff}});
		directed.push_back({16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
			16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000});
		directed.push_back({16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000,
			16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000});
		directed.push_back({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff,
			16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff});
		// tiny triangle near one pole
		directed.push_back({16'sd0, 16'sd0, 16'sd16384, 16'sd1, 16'sd0, 16'sd16384,
			16'sd0, 16'sd1, 16'sd16384});
		// every bit toggled: -1 and alternating patterns
		directed.push_back({16'shffff, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa,
			16'shffff, 16'shaaaa, 16'shffff, 16'sh5555});
		// a at origin, b and c off the sphere
		directed.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd3, 16'sd0, 16'sd0,
			16'sd0, 16'sd5, 16'sd0});

		foreach (directed[i]) send_tri(directed[i]);
		for (int i = 0; i < RandomTriangles; i++) send_tri(sphere_tri());
		tri_ch.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire
